### sv/fir_pkg.sv
// ----------------------------------------------------------------------------
// fir_pkg
// Shared sizes, codes and control types of the direct-form FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

  localparam int MaxTaps     = 128;
  localparam int SampleWidth = 16;

  localparam int TapW       = $clog2(MaxTaps);
  localparam int CntW       = $clog2(MaxTaps + 1);
  localparam int FracW      = SampleWidth - 1;
  localparam int ProdW      = 2 * SampleWidth;
  localparam int AccW       = 2 * SampleWidth + TapW;
  localparam int IdxW       = 7;
  localparam int TapsW      = 8;
  localparam int TapsReset  = 100;
  localparam int ModeW      = 2;
  localparam int InDataW    = ((SampleWidth + IdxW + 7) / 8) * 8;
  localparam int OutDataW   = ((SampleWidth + 7) / 8) * 8;

  typedef enum logic [ModeW-1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_COEF   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            samp_we;
    logic            coef_we;
    logic            clear;
    logic [TapW-1:0] wr_addr;
    logic            issue;
    logic [TapW-1:0] samp_addr;
    logic [TapW-1:0] coef_addr;
    logic            acc_clr;
    logic            load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } ctrl_sts_t;

endpackage

### sv/fir_filter_mac_top.sv
// ----------------------------------------------------------------------------
// fir_filter_mac_top
// Direct-form FIR filter, Q1.15 samples and coefficients, one shared MAC.
// ----------------------------------------------------------------------------
// A sample word (tuser 0) is accepted and then walks n taps, where n is
// taps_in_use held to the range 1 to 128, through the single multiply-
// accumulate; the memory-read, multiply and accumulate stages then drain
// and the result is loaded into the output register. The reset setting is
// 100 taps. A sample word finishes before the next word is taken, and the
// load waits while the previous result still blocks the output register.
// Coefficient writes (tuser 1), clears (tuser 2) and unused codes (tuser 3)
// are taken in the idle state and give no result. A new word is accepted
// while a finished result still waits on the master side. Coefficients and
// samples reset to zero through per-entry valid bits, so there is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module fir_filter_mac_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fir_pkg::TapsW-1:0]      cfg_wdata_i,     // taps_in_use
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [fir_pkg::InDataW-1:0]    s_axis_tdata,    // value, tap_index
  input  logic [fir_pkg::ModeW-1:0]      s_axis_tuser,    // mode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [fir_pkg::OutDataW-1:0]   m_axis_tdata,    // filtered
  output logic                           m_axis_tuser     // saturated
);

  localparam int Sw = fir_pkg::SampleWidth;

  fir_pkg::ctrl_cmd_t   cmd;
  fir_pkg::ctrl_sts_t   sts;
  logic signed [Sw-1:0] filtered;

  fir_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_mode_i      (s_axis_tuser),
    .in_tap_index_i (s_axis_tdata[Sw+fir_pkg::IdxW-1:Sw]),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  fir_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_i     ($signed(s_axis_tdata[Sw-1:0])),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .filtered_o  (filtered),
    .saturated_o (m_axis_tuser)
  );

  assign m_axis_tdata = fir_pkg::OutDataW'($unsigned(filtered));

endmodule

### sv/fir_ctrl.sv
// ----------------------------------------------------------------------------
// fir_ctrl
// Sequencer: decodes input words, walks the taps and hands results out.
// ----------------------------------------------------------------------------
module fir_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fir_pkg::TapsW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fir_pkg::ModeW-1:0]     in_mode_i,
  input  logic [fir_pkg::IdxW-1:0]      in_tap_index_i,
  output fir_pkg::ctrl_cmd_t            cmd_o,
  input  fir_pkg::ctrl_sts_t            sts_i
);

  localparam logic [fir_pkg::TapW-1:0] LastSlot = fir_pkg::TapW'(fir_pkg::MaxTaps - 1);

  fir_pkg::state_e state_q, state_d;
  logic [fir_pkg::TapsW-1:0] taps_q;
  logic [fir_pkg::TapW-1:0]  pos_q, pos_d;
  logic [fir_pkg::TapW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [fir_pkg::CntW-1:0]  k_q, k_d;
  logic [fir_pkg::CntW-1:0]  n_taps;
  logic [fir_pkg::TapW-1:0]  next_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= fir_pkg::TapsW'(fir_pkg::TapsReset);
    end else if (cfg_we_i) begin
      taps_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (taps_q == '0) begin
      n_taps = fir_pkg::CntW'(1);
    end else if (32'(taps_q) > 32'(fir_pkg::MaxTaps)) begin
      n_taps = fir_pkg::CntW'(fir_pkg::MaxTaps);
    end else begin
      n_taps = fir_pkg::CntW'(taps_q);
    end
  end

  assign next_pos = (pos_q == LastSlot) ? '0 : pos_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fir_pkg::ST_IDLE;
      pos_q    <= '0;
      rd_ptr_q <= '0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      rd_ptr_q <= rd_ptr_d;
      k_q      <= k_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    rd_ptr_d   = rd_ptr_q;
    k_d        = k_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.samp_addr = rd_ptr_q;
    cmd_o.coef_addr = k_q[fir_pkg::TapW-1:0];
    cmd_o.wr_addr   = fir_pkg::TapW'(in_tap_index_i);

    unique case (state_q)
      fir_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (fir_pkg::mode_e'(in_mode_i))
            fir_pkg::MODE_SAMPLE: begin
              cmd_o.samp_we = 1'b1;
              cmd_o.wr_addr = next_pos;
              cmd_o.acc_clr = 1'b1;
              pos_d         = next_pos;
              rd_ptr_d      = next_pos;
              k_d           = '0;
              state_d       = fir_pkg::ST_RUN;
            end
            fir_pkg::MODE_COEF: begin
              cmd_o.coef_we = (32'(in_tap_index_i) < 32'(fir_pkg::MaxTaps));
            end
            fir_pkg::MODE_CLEAR: begin
              cmd_o.clear = 1'b1;
              pos_d       = '0;
            end
            default: begin
            end
          endcase
        end
      end
      fir_pkg::ST_RUN: begin
        cmd_o.issue = 1'b1;
        k_d         = k_q + 1'b1;
        rd_ptr_d    = (rd_ptr_q == '0) ? LastSlot : rd_ptr_q - 1'b1;
        if (k_q + 1'b1 == n_taps) begin
          state_d = fir_pkg::ST_DRAIN;
        end
      end
      fir_pkg::ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = fir_pkg::ST_DONE;
        end
      end
      fir_pkg::ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = fir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fir_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### sv/fir_datapath.sv
// ----------------------------------------------------------------------------
// fir_datapath
// Sample and coefficient memories, pipelined multiply-accumulate, rounding,
// saturation and the output register.
// ----------------------------------------------------------------------------
module fir_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fir_pkg::ctrl_cmd_t                   cmd_i,
  output fir_pkg::ctrl_sts_t                   sts_o,
  input  logic signed [fir_pkg::SampleWidth-1:0] value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [fir_pkg::SampleWidth-1:0] filtered_o,
  output logic                                 saturated_o
);

  localparam int Sw = fir_pkg::SampleWidth;
  localparam int Qw = fir_pkg::AccW - fir_pkg::FracW;

  logic signed [Sw-1:0] samp_mem [fir_pkg::MaxTaps];
  logic signed [Sw-1:0] coef_mem [fir_pkg::MaxTaps];
  logic [fir_pkg::MaxTaps-1:0] samp_vld_q;
  logic [fir_pkg::MaxTaps-1:0] coef_vld_q;

  logic signed [Sw-1:0] samp_rd_q, coef_rd_q;
  logic                 samp_rd_vld_q, coef_rd_vld_q;
  logic                 s1_v_q, s2_v_q;
  logic signed [Sw-1:0] op_a, op_b;
  logic signed [fir_pkg::ProdW-1:0] prod_q;
  logic signed [fir_pkg::AccW-1:0]  acc_q;
  logic signed [fir_pkg::AccW-1:0]  rnd;
  logic [Qw-1:0]        q;
  logic                 sat_hi, sat_lo;
  logic signed [Sw-1:0] res;
  logic                 out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.samp_we) begin
      samp_mem[cmd_i.wr_addr] <= value_i;
    end
    if (cmd_i.coef_we) begin
      coef_mem[cmd_i.wr_addr] <= value_i;
    end
    if (cmd_i.issue) begin
      samp_rd_q     <= samp_mem[cmd_i.samp_addr];
      coef_rd_q     <= coef_mem[cmd_i.coef_addr];
      samp_rd_vld_q <= samp_vld_q[cmd_i.samp_addr];
      coef_rd_vld_q <= coef_vld_q[cmd_i.coef_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_vld_q <= '0;
      coef_vld_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        samp_vld_q <= '0;
      end else if (cmd_i.samp_we) begin
        samp_vld_q[cmd_i.wr_addr] <= 1'b1;
      end
      if (cmd_i.coef_we) begin
        coef_vld_q[cmd_i.wr_addr] <= 1'b1;
      end
    end
  end

  // unwritten entries read as zero
  assign op_a = samp_rd_vld_q ? samp_rd_q : '0;
  assign op_b = coef_rd_vld_q ? coef_rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      prod_q <= op_a * op_b;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (s2_v_q) begin
      acc_q <= acc_q + {{(fir_pkg::AccW - fir_pkg::ProdW){prod_q[fir_pkg::ProdW-1]}}, prod_q};
    end
  end

  assign sts_o.pipe_busy = s1_v_q || s2_v_q;

  // round half up, then clip to Q1.15
  assign rnd    = acc_q + (fir_pkg::AccW'(1) << (fir_pkg::FracW - 1));
  assign q      = rnd[fir_pkg::AccW-1:fir_pkg::FracW];
  assign sat_hi = !q[Qw-1] && (q[Qw-2:Sw-1] != '0);
  assign sat_lo = q[Qw-1] && (q[Qw-2:Sw-1] != '1);

  always_comb begin
    priority if (sat_hi) begin
      res = {1'b0, {(Sw-1){1'b1}}};
    end else if (sat_lo) begin
      res = {1'b1, {(Sw-1){1'b0}}};
    end else begin
      res = q[Sw-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      filtered_o  <= res;
      saturated_o <= sat_hi || sat_lo;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

endmodule
